/* rtl/bilinear_crop_resample_core_macros.svh */
// Assertion macros shared by the resampler RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef BILINEAR_CROP_RESAMPLE_CORE_MACROS_SVH
`define BILINEAR_CROP_RESAMPLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRCR_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("brcr: same-cycle check failed");
`define BRCR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("brcr: next-cycle check failed");
`else
`define BRCR_ASSERT_NOW(label, pre, post)
`define BRCR_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* rtl/brcr_pkg.sv */
// Shared types, widths and codes of the bilinear crop resampler.
// No dependencies.
`default_nettype none
package brcr_pkg;
   localparam int STORE_BYTES_DEF = 65536;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int CL_W       = 10;
   localparam int CS_W       = 11;
   localparam int OS_W       = 13;
   localparam int RS_W       = 13;
   localparam int CC_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int ADDR_IN_W  = 16;
   localparam int POS_W      = 12;
   localparam int CH_W       = 2;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 11;
   localparam int WGT_W      = 8;
   localparam int WT_W       = WGT_W + 1;
   localparam int ROWP_W     = COORD_W + RS_W;
   localparam int COLP_W     = COORD_W + CC_W;
   localparam int ASUM_W     = ROWP_W + 1;
   localparam int NSTAGE     = 10;

   localparam logic [WT_W-1:0] WGT_ONE = WT_W'(1 << WGT_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CROP_LEFT     = 3'd0,
      REG_CROP_TOP      = 3'd1,
      REG_CROP_WIDTH    = 3'd2,
      REG_CROP_HEIGHT   = 3'd3,
      REG_OUT_WIDTH     = 3'd4,
      REG_OUT_HEIGHT    = 3'd5,
      REG_ROW_STRIDE    = 3'd6,
      REG_CHANNEL_COUNT = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } axis_en_type;

   typedef struct packed {
      logic s7;
      logic s8;
      logic s9;
      logic s10;
   } blend_en_type;
endpackage
`default_nettype wire

/* rtl/brcr_req_if.sv */
// Request channel: valid/ready handshake with write and sample fields.
// Depends on brcr_pkg.
`default_nettype none
interface brcr_req_if import brcr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [ADDR_IN_W-1:0] write_addr;
   logic [PIX_W-1:0]     write_data;
   logic [POS_W-1:0]     out_x;
   logic [POS_W-1:0]     out_y;
   logic [CH_W-1:0]      channel_sel;

   modport source (output valid, opcode, write_addr, write_data, out_x, out_y, channel_sel,
                   input ready);
   modport sink (input valid, opcode, write_addr, write_data, out_x, out_y, channel_sel,
                 output ready);
endinterface
`default_nettype wire

/* rtl/brcr_rsp_if.sv */
// Response channel: valid/ready handshake with the sample byte.
// Depends on brcr_pkg.
`default_nettype none
interface brcr_rsp_if import brcr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] sample_value;

   modport source (output valid, sample_value, input ready);
   modport sink (input valid, sample_value, output ready);
endinterface
`default_nettype wire

/* rtl/brcr_ram.sv */
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module brcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end
endmodule
`default_nettype wire

/* rtl/brcr_div.sv */
// Restoring divider, one quotient bit per cycle, for the scale factors.
// Depends on the assertion macros header.
`default_nettype none
`include "bilinear_crop_resample_core_macros.svh"
module brcr_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic      [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         quo_ff <= num;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = cnt_ff != '0;
   assign quo  = quo_ff;

   `BRCR_ASSERT_NEXT(a_div_load, start && !reset, cnt_ff == CNT_W'(NUM_W))
   `BRCR_ASSERT_NOW(a_div_rem, busy, rem_ff < den_ff)
endmodule
`default_nettype wire

/* rtl/brcr_axis.sv */
// Source coordinate of one axis: scale multiply, clamp, split into
// neighbours and weight over three stages. Depends on brcr_pkg.
`default_nettype none
module brcr_axis import brcr_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire axis_en_type               en,
   input  wire logic [POS_W-1:0]          pos,
   input  wire logic [CS_W+FRAC_BITS-1:0] scale,
   input  wire logic [CL_W-1:0]           origin,
   input  wire logic [CS_W-1:0]           size_eff,
   output logic      [COORD_W-1:0]        near_ff,
   output logic      [COORD_W-1:0]        far_ff,
   output logic      [WGT_W-1:0]          weight_ff
);
   localparam int SCW = CS_W + FRAC_BITS;
   localparam int PW  = POS_W + 1 + SCW;
   localparam int TW  = PW - 1;
   localparam int DW  = CL_W + FRAC_BITS;
   localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);

   logic [PW-1:0]      prod_ff;
   logic [DW-1:0]      d_ff;
   logic [TW-1:0]      t, lim, dsub, dsel, dclamp;
   logic [CL_W-1:0]    size_m1;
   logic [COORD_W-1:0] near_in, far_in, last;

   always_comb begin
      size_m1 = CL_W'(size_eff - 1'b1);
      t       = prod_ff[PW-1:1];
      lim     = TW'(size_m1) << FRAC_BITS;
      dsub    = t - HALF;
      dsel    = (t < HALF) ? '0 : dsub;
      dclamp  = (dsel > lim) ? lim : dsel;
      near_in = {1'b0, origin} + {1'b0, d_ff[DW-1:FRAC_BITS]};
      last    = {1'b0, origin} + {1'b0, size_m1};
      far_in  = (near_in == last) ? last : near_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= {pos, 1'b1} * scale;
      end
      if (en.s2) begin
         d_ff <= DW'(dclamp);
      end
      if (en.s3) begin
         near_ff   <= near_in;
         far_ff    <= far_in;
         weight_ff <= d_ff[FRAC_BITS-1 -: WGT_W];
      end
   end
endmodule
`default_nettype wire

/* rtl/brcr_blend.sv */
// Bilinear blend of four neighbour bytes, round half up and saturate,
// over four stages ending in the response register. Depends on brcr_pkg.
`default_nettype none
module brcr_blend import brcr_pkg::*; (
   input  wire logic               clock,
   input  wire blend_en_type       en,
   input  wire logic [PIX_W-1:0]   tl,
   input  wire logic [PIX_W-1:0]   tr,
   input  wire logic [PIX_W-1:0]   bl,
   input  wire logic [PIX_W-1:0]   br,
   input  wire logic [WGT_W-1:0]   wx,
   input  wire logic [WGT_W-1:0]   wy,
   output logic      [PIX_W-1:0]   sample_value
);
   localparam int PR_W  = PIX_W + WT_W;
   localparam int ROW_W = PR_W;
   localparam int MV_W  = ROW_W + WT_W;
   localparam int SUM_W = MV_W + 1;
   localparam int SHIFT = 2 * WGT_W;
   localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (SHIFT - 1);
   localparam logic [SUM_W-SHIFT-1:0] VMAX = (SUM_W-SHIFT)'((1 << PIX_W) - 1);

   logic [PR_W-1:0]        p_tl_ff, p_tr_ff, p_bl_ff, p_br_ff;
   logic [ROW_W-1:0]       top_ff, bot_ff;
   logic [MV_W-1:0]        m_top_ff, m_bot_ff;
   logic [WGT_W-1:0]       wy7_ff, wy8_ff;
   logic [PIX_W-1:0]       sample_ff;
   logic [WT_W-1:0]        wxc, wyc;
   logic [SUM_W-1:0]       sum;
   logic [SUM_W-SHIFT-1:0] v;

   always_comb begin
      wxc = WGT_ONE - {1'b0, wx};
      wyc = WGT_ONE - {1'b0, wy8_ff};
      sum = SUM_W'(m_top_ff) + SUM_W'(m_bot_ff) + ROUND;
      v   = sum[SUM_W-1:SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en.s7) begin
         p_tl_ff <= tl * wxc;
         p_tr_ff <= tr * {1'b0, wx};
         p_bl_ff <= bl * wxc;
         p_br_ff <= br * {1'b0, wx};
         wy7_ff  <= wy;
      end
      if (en.s8) begin
         top_ff <= p_tl_ff + p_tr_ff;
         bot_ff <= p_bl_ff + p_br_ff;
         wy8_ff <= wy7_ff;
      end
      if (en.s9) begin
         m_top_ff <= top_ff * wyc;
         m_bot_ff <= bot_ff * {1'b0, wy8_ff};
      end
      if (en.s10) begin
         sample_ff <= (v > VMAX) ? PIX_W'(VMAX) : v[PIX_W-1:0];
      end
   end

   assign sample_value = sample_ff;
endmodule
`default_nettype wire

/* rtl/bilinear_crop_resample_core.sv */
// A sample request gives its response from the last stage; writes give none.
// Throughput: one request per cycle unless the receiver or the divider stalls;
// the 10-stage pipe advances stage by stage. Reset and each csr write start the
// scale divider: requests are held off while it produces one quotient bit per cycle.
// Writes land in the image store in request order ahead of any later reads.
`default_nettype none
`include "bilinear_crop_resample_core_macros.svh"
module bilinear_crop_resample_core import brcr_pkg::*; #(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   brcr_req_if.sink                   req_chan,
   brcr_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW  = $clog2(STORE_BYTES);
   localparam int SCW = CS_W + FRAC_BITS;

   logic [CL_W-1:0] crop_left_ff, crop_top_ff;
   logic [CS_W-1:0] crop_width_ff, crop_height_ff, cw_eff, ch_eff;
   logic [OS_W-1:0] out_width_ff, out_height_ff, ow_eff, oh_eff;
   logic [RS_W-1:0] row_stride_ff;
   logic [CC_W-1:0] channel_count_ff;
   logic            pend_ff;
   logic            dx_busy, dy_busy, busy;
   logic [SCW-1:0]  scale_x, scale_y;

   logic [NSTAGE:1]   v_ff, v_in;
   logic [NSTAGE+1:1] en;

   logic             op_ff    [1:5];
   logic [AW-1:0]    waddr_ff [1:5];
   logic [PIX_W-1:0] wdata_ff [1:5];
   logic [CH_W-1:0]  chan_ff  [1:4];
   logic [WGT_W-1:0] wgt_x_ff [4:6];
   logic [WGT_W-1:0] wgt_y_ff [4:6];

   logic [COORD_W-1:0] x_near, x_far, y_near, y_far;
   logic [WGT_W-1:0]   x_wgt, y_wgt;
   logic [ROWP_W-1:0]  ys0_ff, ys1_ff;
   logic [COLP_W-1:0]  xc0_ff, xc1_ff;
   logic [AW-1:0]      addr_tl_ff, addr_tr_ff, addr_bl_ff, addr_br_ff;
   logic [PIX_W-1:0]   d_tl, d_tr, d_bl, d_br;
   logic               ram_we;
   axis_en_type        axis_en;
   blend_en_type       blend_en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         crop_left_ff     <= '0;
         crop_top_ff      <= '0;
         crop_width_ff    <= CS_W'(1);
         crop_height_ff   <= CS_W'(1);
         out_width_ff     <= OS_W'(1);
         out_height_ff    <= OS_W'(1);
         row_stride_ff    <= RS_W'(1);
         channel_count_ff <= CC_W'(1);
         pend_ff          <= 1'b1;
      end else begin
         pend_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               REG_CROP_LEFT:     crop_left_ff     <= csr_wdata[CL_W-1:0];
               REG_CROP_TOP:      crop_top_ff      <= csr_wdata[CL_W-1:0];
               REG_CROP_WIDTH:    crop_width_ff    <= csr_wdata[CS_W-1:0];
               REG_CROP_HEIGHT:   crop_height_ff   <= csr_wdata[CS_W-1:0];
               REG_OUT_WIDTH:     out_width_ff     <= csr_wdata[OS_W-1:0];
               REG_OUT_HEIGHT:    out_height_ff    <= csr_wdata[OS_W-1:0];
               REG_ROW_STRIDE:    row_stride_ff    <= csr_wdata[RS_W-1:0];
               REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CC_W-1:0];
            endcase
         end
      end
   end

   always_comb begin
      cw_eff = (crop_width_ff == '0) ? CS_W'(1) : crop_width_ff;
      ch_eff = (crop_height_ff == '0) ? CS_W'(1) : crop_height_ff;
      ow_eff = (out_width_ff == '0) ? OS_W'(1) : out_width_ff;
      oh_eff = (out_height_ff == '0) ? OS_W'(1) : out_height_ff;
   end

   brcr_div #(.NUM_W(SCW), .DEN_W(OS_W)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (pend_ff),
      .num   (SCW'(cw_eff) << FRAC_BITS),
      .den   (ow_eff),
      .busy  (dx_busy),
      .quo   (scale_x)
   );

   brcr_div #(.NUM_W(SCW), .DEN_W(OS_W)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (pend_ff),
      .num   (SCW'(ch_eff) << FRAC_BITS),
      .den   (oh_eff),
      .busy  (dy_busy),
      .quo   (scale_y)
   );

   assign busy = pend_ff | dx_busy | dy_busy;

   // pipeline control: a stage advances when empty or when its successor does
   always_comb begin
      en[NSTAGE+1] = rsp_chan.ready;
      for (int k = NSTAGE; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 1; k <= NSTAGE; k++) begin
         if (!en[k]) begin
            v_in[k] = v_ff[k];
         end else if (k == 1) begin
            v_in[k] = req_chan.valid && !busy;
         end else if (k == 6) begin
            v_in[k] = v_ff[5] && (op_ff[5] == OP_SAMPLE);
         end else begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[1] && !busy;
   assign rsp_chan.valid = v_ff[NSTAGE];

   // request fields travel along with the coordinate stages
   always_ff @(posedge clock) begin
      if (en[1]) begin
         op_ff[1]    <= req_chan.opcode;
         waddr_ff[1] <= AW'(req_chan.write_addr);
         wdata_ff[1] <= req_chan.write_data;
         chan_ff[1]  <= req_chan.channel_sel;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            op_ff[k]    <= op_ff[k-1];
            waddr_ff[k] <= waddr_ff[k-1];
            wdata_ff[k] <= wdata_ff[k-1];
         end
      end
      for (int k = 2; k <= 4; k++) begin
         if (en[k]) begin
            chan_ff[k] <= chan_ff[k-1];
         end
      end
   end

   assign axis_en.s1 = en[1];
   assign axis_en.s2 = en[2];
   assign axis_en.s3 = en[3];

   brcr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock     (clock),
      .en        (axis_en),
      .pos       (req_chan.out_x),
      .scale     (scale_x),
      .origin    (crop_left_ff),
      .size_eff  (cw_eff),
      .near_ff   (x_near),
      .far_ff    (x_far),
      .weight_ff (x_wgt)
   );

   brcr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock     (clock),
      .en        (axis_en),
      .pos       (req_chan.out_y),
      .scale     (scale_y),
      .origin    (crop_top_ff),
      .size_eff  (ch_eff),
      .near_ff   (y_near),
      .far_ff    (y_far),
      .weight_ff (y_wgt)
   );

   // address generation
   always_ff @(posedge clock) begin
      if (en[4]) begin
         ys0_ff      <= y_near * row_stride_ff;
         ys1_ff      <= y_far * row_stride_ff;
         xc0_ff      <= x_near * channel_count_ff;
         xc1_ff      <= x_far * channel_count_ff;
         wgt_x_ff[4] <= x_wgt;
         wgt_y_ff[4] <= y_wgt;
      end
      if (en[5]) begin
         addr_tl_ff  <= AW'(ASUM_W'(ys0_ff) + ASUM_W'(xc0_ff) + ASUM_W'(chan_ff[4]));
         addr_tr_ff  <= AW'(ASUM_W'(ys0_ff) + ASUM_W'(xc1_ff) + ASUM_W'(chan_ff[4]));
         addr_bl_ff  <= AW'(ASUM_W'(ys1_ff) + ASUM_W'(xc0_ff) + ASUM_W'(chan_ff[4]));
         addr_br_ff  <= AW'(ASUM_W'(ys1_ff) + ASUM_W'(xc1_ff) + ASUM_W'(chan_ff[4]));
         wgt_x_ff[5] <= wgt_x_ff[4];
         wgt_y_ff[5] <= wgt_y_ff[4];
      end
      if (en[6]) begin
         wgt_x_ff[6] <= wgt_x_ff[5];
         wgt_y_ff[6] <= wgt_y_ff[5];
      end
   end

   // two copies of the image: upper row pair and lower row pair
   assign ram_we = en[6] && v_ff[5] && (op_ff[5] == OP_WRITE);

   brcr_ram #(.WIDTH(PIX_W), .DEPTH(STORE_BYTES)) u_ram_upper (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (waddr_ff[5]),
      .wdata   (wdata_ff[5]),
      .re      (en[6]),
      .raddr_a (addr_tl_ff),
      .raddr_b (addr_tr_ff),
      .rdata_a (d_tl),
      .rdata_b (d_tr)
   );

   brcr_ram #(.WIDTH(PIX_W), .DEPTH(STORE_BYTES)) u_ram_lower (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (waddr_ff[5]),
      .wdata   (wdata_ff[5]),
      .re      (en[6]),
      .raddr_a (addr_bl_ff),
      .raddr_b (addr_br_ff),
      .rdata_a (d_bl),
      .rdata_b (d_br)
   );

   assign blend_en.s7  = en[7];
   assign blend_en.s8  = en[8];
   assign blend_en.s9  = en[9];
   assign blend_en.s10 = en[10];

   brcr_blend u_blend (
      .clock        (clock),
      .en           (blend_en),
      .tl           (d_tl),
      .tr           (d_tr),
      .bl           (d_bl),
      .br           (d_br),
      .wx           (wgt_x_ff[6]),
      .wy           (wgt_y_ff[6]),
      .sample_value (rsp_chan.sample_value)
   );

   `BRCR_ASSERT_NEXT(a_csr_holds_off, csr_we, !req_chan.ready)
   `BRCR_ASSERT_NEXT(a_rsp_holds, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.sample_value))
   `BRCR_ASSERT_NEXT(a_write_no_rsp, v_ff[5] && (op_ff[5] == OP_WRITE) && en[6], !v_ff[6])
endmodule
`default_nettype wire

/* sim/brcr_resample_checker.sv */
// Checker for the bilinear crop resampler: tracks csr writes and store writes,
// predicts each sample byte and compares it with the response channel.
// Depends on brcr_pkg, brcr_req_if and brcr_rsp_if.
`default_nettype none
module brcr_resample_checker import brcr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   brcr_req_if                        req_chan,
   brcr_rsp_if                        rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         error_count,
   output int                         pending_count,
   output int                         sample_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRAC_BITS_DEF;

   logic [PIX_W-1:0] pixel_mem [0:STORE_BYTES_DEF-1];
   logic [CL_W-1:0]  left_q, top_q;
   logic [CS_W-1:0]  cw_q, ch_q;
   logic [OS_W-1:0]  ow_q, oh_q;
   logic [RS_W-1:0]  stride_q;
   logic [CC_W-1:0]  chans_q;
   logic [PIX_W-1:0] sample_queue [$];

   task automatic report_mismatch(input string what);
      $display("%0t MISMATCH: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void map_axis(input longint origin, input longint size,
         input longint osize, input longint pos,
         output longint near, output longint far, output longint wgt);
      longint sz, osz, scale, lo, last, hi, c;
      sz = (size == 0) ? 1 : size;
      osz = (osize == 0) ? 1 : osize;
      scale = (sz << FB) / osz;
      lo = origin << FB;
      last = origin + sz - 1;
      hi = last << FB;
      c = lo + (((2 * pos + 1) * scale) >> 1);
      if (c < lo + (64'd1 << (FB - 1))) c = lo;
      else c -= (64'd1 << (FB - 1));
      if (c > hi) c = hi;
      near = c >> FB;
      wgt = (c & ((64'd1 << FB) - 1)) >> (FB - 8);
      far = (near + 1 < last) ? near + 1 : last;
   endfunction

   function automatic longint read_byte(input longint x, input longint y, input longint c);
      longint a;
      a = y * stride_q + x * chans_q + c;
      return pixel_mem[a % STORE_BYTES_DEF];
   endfunction

   function automatic logic [PIX_W-1:0] interpolate(input longint px, input longint py,
         input longint c);
      longint x0, x1, wx, y0, y1, wy, upper, lower, v;
      map_axis(left_q, cw_q, ow_q, px, x0, x1, wx);
      map_axis(top_q, ch_q, oh_q, py, y0, y1, wy);
      upper = read_byte(x0, y0, c) * (256 - wx) + read_byte(x1, y0, c) * wx;
      lower = read_byte(x0, y1, c) * (256 - wx) + read_byte(x1, y1, c) * wx;
      v = (upper * (256 - wy) + lower * wy + 32768) >> 16;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   assign pending_count = sample_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         left_q <= '0; top_q <= '0; cw_q <= 1; ch_q <= 1;
         ow_q <= 1; oh_q <= 1; stride_q <= 1; chans_q <= 1;
         sample_queue.delete();
         error_count <= 0;
         sample_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_CROP_LEFT:     left_q   <= CL_W'(csr_wdata);
               REG_CROP_TOP:      top_q    <= CL_W'(csr_wdata);
               REG_CROP_WIDTH:    cw_q     <= CS_W'(csr_wdata);
               REG_CROP_HEIGHT:   ch_q     <= CS_W'(csr_wdata);
               REG_OUT_WIDTH:     ow_q     <= csr_wdata;
               REG_OUT_HEIGHT:    oh_q     <= csr_wdata;
               REG_ROW_STRIDE:    stride_q <= csr_wdata;
               REG_CHANNEL_COUNT: chans_q  <= CC_W'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sample_count <= sample_count + 1;
            if (sample_queue.size() == 0)
               report_mismatch($sformatf("unexpected response %0d", rsp_chan.sample_value));
            else if (rsp_chan.sample_value !== sample_queue[0]) begin
               report_mismatch($sformatf("sample_value %0d, predicted %0d",
                  rsp_chan.sample_value, sample_queue[0]));
               void'(sample_queue.pop_front());
            end else
               void'(sample_queue.pop_front());
         end
         if (req_chan.valid && req_chan.ready) begin
            if (opcode_type'(req_chan.opcode) == OP_WRITE)
               pixel_mem[req_chan.write_addr] = req_chan.write_data;
            else
               sample_queue.push_back(interpolate(req_chan.out_x, req_chan.out_y,
                  req_chan.channel_sel));
         end
      end
   end
endmodule
`default_nettype wire

/* sim/tb_bilinear_crop_resample_core.sv */
// Top of the resampler testbench: drives csr writes and bursty requests with a
// stalling receiver; the checker module predicts and compares.
// Depends on brcr_pkg, the channel interfaces, the core and brcr_resample_checker.
`default_nettype none
module tb_bilinear_crop_resample_core;
   import brcr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int error_count, pending_count, sample_count;
   int idle_cycles = 0;
   int hold_off = 0;
   logic written [0:STORE_BYTES_DEF-1];
   int write_total = 0;

   brcr_req_if req_chan();
   brcr_rsp_if rsp_chan();

   bilinear_crop_resample_core uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   brcr_resample_checker checker_i (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count),
      .sample_count(sample_count));

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_WRITE;
      req_chan.write_addr = '0;
      req_chan.write_data = '0;
      req_chan.out_x = '0;
      req_chan.out_y = '0;
      req_chan.channel_sel = '0;
      rsp_chan.ready = 1'b0;
      foreach (written[i]) written[i] = 1'b0;
   end

   // receiver: stall pattern, with one long hold-off requested by the sender side
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else
         rsp_chan.ready <= (sample_count % 64 < 20) ? 1'b1 : ($urandom_range(3) != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(posedge clock);
      wait (idle_cycles >= IDLE_LIMIT);
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // hold until every response is in, then let the pipe drain
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send(input logic op, input int addr, input int data,
                       input int px, input int py, input int chan);
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.write_addr <= ADDR_IN_W'(addr);
      req_chan.write_data <= PIX_W'(data);
      req_chan.out_x <= POS_W'(px);
      req_chan.out_y <= POS_W'(py);
      req_chan.channel_sel <= CH_W'(chan);
      do @(posedge clock); while (!req_chan.ready);
      if (op == OP_WRITE) begin
         written[addr % STORE_BYTES_DEF] = 1'b1;
         write_total++;
      end
   endtask

   task automatic gap();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic store_byte(input int addr, input int data);
      send(OP_WRITE, addr, data, $urandom, $urandom, $urandom);
   endtask

   // callers drop valid before this
   task automatic set_geometry(input int cl, input int ct, input int cw, input int chh,
         input int ow, input int oh, input int rs, input int cc);
      drain();
      write_reg(REG_CROP_LEFT, cl);
      write_reg(REG_CROP_TOP, ct);
      write_reg(REG_CROP_WIDTH, cw);
      write_reg(REG_CROP_HEIGHT, chh);
      write_reg(REG_OUT_WIDTH, ow);
      write_reg(REG_OUT_HEIGHT, oh);
      write_reg(REG_ROW_STRIDE, rs);
      write_reg(REG_CHANNEL_COUNT, cc);
      csr_we <= 1'b0;
   endtask

   // fill every byte that crop geometry can touch, keeping the address set small
   task automatic fill_crop(input int cl, input int ct, input int cw, input int chh,
         input int rs, input int cc, input bit extreme);
      int x, y, c, wv, hv;
      wv = (cw == 0) ? 1 : cw;
      hv = (chh == 0) ? 1 : chh;
      for (y = ct; y < ct + hv; y++)
         for (x = cl; x < cl + wv; x++)
            for (c = 0; c < 4; c++) begin
               int a;
               a = (y * rs + x * cc + c) % STORE_BYTES_DEF;
               if (!written[a]) begin
                  store_byte(a, extreme ? (($urandom_range(1)) ? 255 : 0) : $urandom_range(255));
                  if ($urandom_range(7) == 0) gap();
               end
            end
   endtask

   task automatic sample_burst(input int count, input int ow, input int oh);
      int k;
      for (k = 0; k < count; k++) begin
         int px, py;
         px = ($urandom_range(9) == 0) ? $urandom : $urandom_range(ow + 1);
         py = ($urandom_range(9) == 0) ? $urandom : $urandom_range(oh + 1);
         send(OP_SAMPLE, $urandom, $urandom, px, py, $urandom_range(3));
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(4)) gap();
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int phase, cl, ct, cw, chh, ow, oh, rs, cc, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: single pixel at address 0, extreme sample fields
      store_byte(0, 255);
      store_byte(16'hFFFF, 0);
      send(OP_SAMPLE, 16'hFFFF, 8'hFF, 0, 0, 0);
      send(OP_SAMPLE, 0, 0, 4095, 4095, 0);
      store_byte(1, 8'hA5);
      send(OP_SAMPLE, 0, 0, 0, 0, 1);
      req_chan.valid <= 1'b0;

      // zero sizes, zero stride and count, crop at the far corner wrapping the store
      set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
      fill_crop(0, 0, 0, 0, 0, 0, 1);
      sample_burst(4, 1, 1);
      set_geometry(1023, 1023, 2, 2, 4096, 1, 4096, 4);
      fill_crop(1023, 1023, 2, 2, 4096, 4, 1);
      sample_burst(8, 4096, 1);
      set_geometry(0, 0, 1024, 1, 1, 4096, 4096, 1);
      fill_crop(0, 0, 40, 1, 4096, 1, 0);
      for (n = 0; n < 40; n++) written[n] = written[n];
      req_chan.valid <= 1'b0;

      // random geometries; keep crop small so the fill stays short
      for (phase = 0; phase < 14; phase++) begin
         cl = $urandom_range(1023);
         ct = $urandom_range(1023);
         cw = $urandom_range(1, 4);
         chh = $urandom_range(1, 4);
         ow = (phase % 5 == 0) ? 4096 : $urandom_range(1, 12);
         oh = (phase % 7 == 0) ? 4096 : $urandom_range(1, 12);
         rs = (phase % 4 == 0) ? $urandom_range(1, 4096) : $urandom_range(8, 40);
         cc = $urandom_range(1, 4);
         set_geometry(cl, ct, cw, chh, ow, oh, rs, cc);
         fill_crop(cl, ct, cw, chh, rs, cc, phase == 3);
         if (phase == 5) begin
            hold_off <= 200;
            sample_burst(60, ow, oh);
         end else
            sample_burst(25, ow < 12 ? ow : 12, oh < 12 ? oh : 12);
      end

      drain();
      $display("covered %0d store writes and %0d sample responses over 17 geometries",
         write_total, sample_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
